@@ design/assert_macros.svh @@
// Assertion macros for the cone direction sampler; used by cds_setup.
// Needs clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define CDS_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define CDS_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/cds_pkg.sv @@
// Types, Q30 constants and CORDIC / square root step functions
// for the cone direction sampler. No dependencies.
package cds_pkg;

  typedef logic signed [33:0] ang_t;

  localparam ang_t PI_Q30         = 34'sd3373259426;
  localparam ang_t HALF_PI_Q30    = 34'sd1686629713;
  localparam ang_t THREE_HALF_Q30 = 34'sd5059889139;
  localparam ang_t TWO_PI_Q30     = 34'sd6746518852;
  localparam ang_t CORDIC_K_Q30   = 34'sd652032874;
  localparam logic signed [31:0] ONE_Q30  = 32'sd1073741824;
  localparam logic signed [31:0] NEAR_Q30 = 32'sd1063004406;
  localparam logic [32:0] TWO_PI_U = 33'd6746518852;

  localparam logic [2:0] REG_HALF_ANGLE = 3'd0;
  localparam logic [2:0] REG_AXIS_X     = 3'd1;
  localparam logic [2:0] REG_AXIS_Y     = 3'd2;
  localparam logic [2:0] REG_AXIS_Z     = 3'd3;

  typedef struct packed {
    ang_t x;
    ang_t y;
    ang_t z;
    logic neg;
  } rot_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] res;
  } root_t;

  typedef logic [2:0][31:0] vec3_t;

  typedef struct packed {
    logic        ready;
    logic [31:0] minc;
    vec3_t       fwd;
    vec3_t       rgt;
    vec3_t       upv;
  } frame_t;

  typedef enum logic [2:0] {
    ST_START, ST_TRIG, ST_SQ, ST_SHIFT, ST_ROOT, ST_DIV, ST_CROSS, ST_DONE
  } setup_state_t;

  function automatic ang_t atan_q30(input logic [4:0] i);
    ang_t a;
    case (i)
      5'd0:  a = 34'sh3243F6A8;
      5'd1:  a = 34'sh1DAC6705;
      5'd2:  a = 34'sh0FADBAFC;
      5'd3:  a = 34'sh07F56EA6;
      5'd4:  a = 34'sh03FEAB76;
      5'd5:  a = 34'sh01FFD55B;
      5'd6:  a = 34'sh00FFFAAA;
      5'd7:  a = 34'sh007FFF55;
      5'd8:  a = 34'sh003FFFEA;
      5'd9:  a = 34'sh001FFFFD;
      5'd10: a = 34'sh000FFFFF;
      5'd11: a = 34'sh0007FFFF;
      5'd12: a = 34'sh0003FFFF;
      5'd13: a = 34'sh0001FFFF;
      5'd14: a = 34'sh0000FFFF;
      5'd15: a = 34'sh00007FFF;
      5'd16: a = 34'sh00003FFF;
      5'd17: a = 34'sh00001FFF;
      5'd18: a = 34'sh00000FFF;
      5'd19: a = 34'sh000007FF;
      5'd20: a = 34'sh000003FF;
      5'd21: a = 34'sh000001FF;
      5'd22: a = 34'sh000000FF;
      5'd23: a = 34'sh0000007F;
      5'd24: a = 34'sh0000003F;
      5'd25: a = 34'sh0000001F;
      5'd26: a = 34'sh0000000F;
      5'd27: a = 34'sh00000008;
      5'd28: a = 34'sh00000004;
      5'd29: a = 34'sh00000002;
      default: a = '0;
    endcase
    return a;
  endfunction

  // fold an angle in [0, 2pi) into [-pi/2, pi/2] and load the CORDIC start
  function automatic rot_t cordic_init(input ang_t a);
    rot_t o;
    o.x = CORDIC_K_Q30;
    o.y = '0;
    o.neg = 1'b0;
    if (a > HALF_PI_Q30 && a <= THREE_HALF_Q30) begin
      o.z = a - PI_Q30;
      o.neg = 1'b1;
    end else if (a > THREE_HALF_Q30) begin
      o.z = a - TWO_PI_Q30;
    end else begin
      o.z = a;
    end
    return o;
  endfunction

  function automatic rot_t cordic_step(input rot_t c, input logic [4:0] i);
    rot_t o;
    ang_t dx;
    ang_t dy;
    ang_t a;
    dx = $signed(c.y) >>> i;
    dy = $signed(c.x) >>> i;
    a = atan_q30(i);
    o.neg = c.neg;
    if (!c.z[33]) begin
      o.x = c.x - dx;
      o.y = c.y + dy;
      o.z = c.z - a;
    end else begin
      o.x = c.x + dx;
      o.y = c.y - dy;
      o.z = c.z + a;
    end
    return o;
  endfunction

  function automatic root_t root_step(input root_t r, input logic [63:0] bv);
    root_t o;
    logic [63:0] t;
    t = r.res + bv;
    if (r.rem >= t) begin
      o.rem = r.rem - t;
      o.res = (r.res >> 1) + bv;
    end else begin
      o.rem = r.rem;
      o.res = r.res >> 1;
    end
    return o;
  endfunction

endpackage

@@ design/cone_direction_sampler_unit.sv @@
// Cone direction sampler top level: config setup sequencer plus item pipeline.
// Depends on cds_pkg, cds_setup, cds_item_pipe.
// One item per cycle while neither out_stall nor the frame setup holds the input.
// The pipeline stalls as a whole only while a finished result waits on out_stall.
// After reset and after any config write, in_stall holds for the frame setup,
// which runs the serial square root and divide loop.
module cone_direction_sampler_unit import cds_pkg::*; #(
  parameter int RAND_BITS = 24,
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [RAND_BITS-1:0] in_rand_polar,
  input  logic [RAND_BITS-1:0] in_rand_azimuth,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [17:0]   out_heading_x,
  output logic signed [17:0]   out_heading_y,
  output logic signed [17:0]   out_heading_z,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [23:0]          cfg_wdata
);

  frame_t frame;
  logic   adv;
  logic   take;

  assign adv = !out_valid || !out_stall;
  assign in_stall = !(adv && frame.ready);
  assign take = in_valid && !in_stall;

  cds_setup #(
    .FRAC_BITS(FRAC_BITS)
  ) u_setup (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .frame(frame)
  );

  cds_item_pipe #(
    .RAND_BITS(RAND_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) u_pipe (
    .clk(clk),
    .rst_n(rst_n),
    .adv(adv),
    .take(take),
    .rand_polar(in_rand_polar),
    .rand_azimuth(in_rand_azimuth),
    .frame(frame),
    .out_valid(out_valid),
    .heading_x(out_heading_x),
    .heading_y(out_heading_y),
    .heading_z(out_heading_z)
  );

endmodule

@@ design/cds_setup.sv @@
// Configuration registers and frame setup sequencer: cos of the half angle,
// normalized axis, right and up vectors. Depends on cds_pkg, assert_macros.svh.
`include "assert_macros.svh"

module cds_setup import cds_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_wdata,
  output frame_t      frame
);

  setup_state_t state_r, state_nxt;

  logic [17:0] half_r;
  logic [23:0] ax_r, ay_r, az_r;
  logic [6:0]  cnt_r;
  logic [1:0]  k_r;
  logic        ph_r;
  logic        pass_r;
  logic [4:0]  s_r;
  rot_t        rot_r;
  logic [31:0] minc_r;
  vec3_t       nv_r, nres_r, fwd_r, rgt_r, upv_r;
  logic [63:0] len2_r;
  root_t       root_r;
  logic [63:0] bv_r;
  logic [30:0] lrt_r;
  logic [30:0] rem_r;
  logic [31:0] quo_r;
  logic signed [63:0] acc_r;

  logic [39:0] h_wide;
  ang_t        h_ang;
  rot_t        rot_step;
  ang_t        cx;
  logic [31:0] minc_nxt;
  logic signed [31:0] nvk;
  logic [30:0] m_w;
  logic [61:0] msq;
  logic        shift_go;
  root_t       root_nxt;
  logic        dbit;
  logic [31:0] dwide;
  logic        dge;
  logic [31:0] quo_nxt;
  logic [31:0] qclamp;
  logic [31:0] qval;
  logic        div_last;
  vec3_t       fin_vec;
  logic [1:0]  i1, i2;
  logic signed [63:0] prod_ab, prod_cd, up_full;

  function automatic vec3_t helper_of(input vec3_t f);
    vec3_t h;
    logic signed [31:0] fy;
    fy = $signed(f[1]);
    if ((fy[31] ? -fy : fy) < NEAR_Q30) begin
      h[0] = f[2];
      h[1] = '0;
      h[2] = -f[0];
    end else begin
      h[0] = '0;
      h[1] = -f[2];
      h[2] = f[1];
    end
    return h;
  endfunction

  always_comb begin
    h_wide = 40'(half_r) << (30 - FRAC_BITS);
    h_ang = (h_wide > 40'(PI_Q30)) ? PI_Q30 : $signed(h_wide[33:0]);
    rot_step = cordic_step(rot_r, cnt_r[4:0]);
    cx = rot_step.neg ? -rot_step.x : rot_step.x;
    if (cx > 34'sd1073741824) begin
      minc_nxt = ONE_Q30;
    end else if (cx < -34'sd1073741824) begin
      minc_nxt = -ONE_Q30;
    end else begin
      minc_nxt = cx[31:0];
    end
    nvk = $signed(nv_r[k_r]);
    m_w = nvk[31] ? 31'(-nvk) : 31'(nvk);
    msq = 62'(m_w) * 62'(m_w);
    shift_go = (s_r < 5'd30) && (len2_r[63:60] == 4'd0);
    root_nxt = root_step(root_r, bv_r);
    dbit = (cnt_r < 7'd31) ? m_w[5'(7'd30 - cnt_r)] : 1'b0;
    dwide = {rem_r, dbit};
    dge = dwide >= {1'b0, lrt_r};
    quo_nxt = {quo_r[30:0], dge};
    qclamp = (quo_nxt > 32'(ONE_Q30)) ? 32'(ONE_Q30) : quo_nxt;
    qval = nvk[31] ? -qclamp : qclamp;
    div_last = (cnt_r == 7'd60 + 7'(s_r));
    fin_vec = nres_r;
    fin_vec[k_r] = qval;
    case (k_r)
      2'd0: begin
        i1 = 2'd1;
        i2 = 2'd2;
      end
      2'd1: begin
        i1 = 2'd2;
        i2 = 2'd0;
      end
      default: begin
        i1 = 2'd0;
        i2 = 2'd1;
      end
    endcase
    prod_ab = $signed(fwd_r[i1]) * $signed(rgt_r[i2]);
    prod_cd = $signed(fwd_r[i2]) * $signed(rgt_r[i1]);
    up_full = (acc_r - prod_cd) >>> 30;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_START: state_nxt = ST_TRIG;
      ST_TRIG: if (cnt_r == 7'd29) state_nxt = ST_SQ;
      ST_SQ: if (k_r == 2'd2) state_nxt = ST_SHIFT;
      ST_SHIFT: begin
        if (!shift_go) begin
          if (len2_r == '0) begin
            state_nxt = pass_r ? ST_CROSS : ST_SQ;
          end else begin
            state_nxt = ST_ROOT;
          end
        end
      end
      ST_ROOT: if (cnt_r == 7'd31) state_nxt = ST_DIV;
      ST_DIV: if (div_last && k_r == 2'd2) state_nxt = pass_r ? ST_CROSS : ST_SQ;
      ST_CROSS: if (ph_r && k_r == 2'd2) state_nxt = ST_DONE;
      ST_DONE: state_nxt = ST_DONE;
      default: state_nxt = ST_START;
    endcase
    if (cfg_we) state_nxt = ST_START;
  end

  always_comb begin
    frame.ready = (state_r == ST_DONE);
    frame.minc = minc_r;
    frame.fwd = fwd_r;
    frame.rgt = rgt_r;
    frame.upv = upv_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_START;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= '0;
      ax_r <= '0;
      ay_r <= 24'd65536;
      az_r <= '0;
      cnt_r <= '0;
      k_r <= '0;
      ph_r <= 1'b0;
      pass_r <= 1'b0;
      s_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_HALF_ANGLE: half_r <= cfg_wdata[17:0];
          REG_AXIS_X: ax_r <= cfg_wdata;
          REG_AXIS_Y: ay_r <= cfg_wdata;
          REG_AXIS_Z: az_r <= cfg_wdata;
          default: ;
        endcase
      end
      case (state_r)
        ST_START: begin
          rot_r <= cordic_init(h_ang);
          cnt_r <= '0;
        end
        ST_TRIG: begin
          rot_r <= rot_step;
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'd29) begin
            minc_r <= minc_nxt;
            nv_r[0] <= 32'($signed(ax_r));
            nv_r[1] <= 32'($signed(ay_r));
            nv_r[2] <= 32'($signed(az_r));
            pass_r <= 1'b0;
            k_r <= '0;
            len2_r <= '0;
            s_r <= '0;
          end
        end
        ST_SQ: begin
          len2_r <= len2_r + 64'(msq);
          k_r <= (k_r == 2'd2) ? 2'd0 : k_r + 2'd1;
        end
        ST_SHIFT: begin
          if (shift_go) begin
            len2_r <= len2_r << 2;
            s_r <= s_r + 5'd1;
          end else if (len2_r == '0) begin
            if (!pass_r) begin
              fwd_r <= {32'd0, 32'(ONE_Q30), 32'd0};
              nv_r <= helper_of({32'd0, 32'(ONE_Q30), 32'd0});
              pass_r <= 1'b1;
              k_r <= '0;
              len2_r <= '0;
              s_r <= '0;
            end else begin
              rgt_r <= {32'd0, 32'd0, 32'(ONE_Q30)};
              k_r <= '0;
              ph_r <= 1'b0;
            end
          end else begin
            root_r <= '{rem: len2_r, res: 64'd0};
            bv_r <= 64'd1 << 62;
            cnt_r <= '0;
          end
        end
        ST_ROOT: begin
          root_r <= root_nxt;
          bv_r <= bv_r >> 2;
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'd31) begin
            lrt_r <= root_nxt.res[30:0];
            k_r <= '0;
            cnt_r <= '0;
            rem_r <= '0;
            quo_r <= '0;
          end
        end
        ST_DIV: begin
          rem_r <= dge ? 31'(dwide - {1'b0, lrt_r}) : dwide[30:0];
          quo_r <= quo_nxt;
          cnt_r <= cnt_r + 7'd1;
          if (div_last) begin
            nres_r[k_r] <= qval;
            k_r <= (k_r == 2'd2) ? 2'd0 : k_r + 2'd1;
            cnt_r <= '0;
            rem_r <= '0;
            quo_r <= '0;
            if (k_r == 2'd2) begin
              if (!pass_r) begin
                fwd_r <= fin_vec;
                nv_r <= helper_of(fin_vec);
                pass_r <= 1'b1;
                len2_r <= '0;
                s_r <= '0;
              end else begin
                rgt_r <= fin_vec;
                ph_r <= 1'b0;
              end
            end
          end
        end
        ST_CROSS: begin
          if (!ph_r) begin
            acc_r <= prod_ab;
            ph_r <= 1'b1;
          end else begin
            upv_r[k_r] <= up_full[31:0];
            ph_r <= 1'b0;
            k_r <= (k_r == 2'd2) ? 2'd0 : k_r + 2'd1;
          end
        end
        ST_DONE: ;
        default: ;
      endcase
    end
  end

  `CDS_CHECK_NEXT(a_cfg_drops_ready, cfg_we, !frame.ready, "frame ready after config write")
  `CDS_CHECK(a_minc_range, frame.ready, ($signed(minc_r) <= ONE_Q30) && ($signed(minc_r) >= -ONE_Q30), "cos of half angle out of range")
  `CDS_CHECK(a_fwd_y_range, frame.ready, ($signed(fwd_r[1]) <= ONE_Q30) && ($signed(fwd_r[1]) >= -ONE_Q30), "forward y out of range")

endmodule

@@ design/cds_item_pipe.sv @@
// Per-item pipeline: cos/sin of the polar angle, azimuth CORDIC, local
// direction and rotation into the configured frame. Depends on cds_pkg.
module cds_item_pipe import cds_pkg::*; #(
  parameter int RAND_BITS = 24,
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 take,
  input  logic [RAND_BITS-1:0] rand_polar,
  input  logic [RAND_BITS-1:0] rand_azimuth,
  input  frame_t               frame,
  output logic                 out_valid,
  output logic signed [17:0]   heading_x,
  output logic signed [17:0]   heading_y,
  output logic signed [17:0]   heading_z
);

  localparam int NSTAGE = 39;

  logic [NSTAGE-1:0] vld_r;

  logic [29:0] up_r, ua_r;
  logic [61:0] pc_r;
  logic [32:0] phi_r;
  logic [31:0] cost2_r;
  rot_t        rot2_r;
  rot_t        rs_r [0:32];
  root_t       qs_r [0:32];
  logic [31:0] cs_r [0:32];
  logic signed [33:0] loc0_r, loc1_r;
  logic signed [31:0] loc2_r;
  logic signed [63:0] pr_r [0:2][0:2];
  logic [17:0] hd_r [0:2];

  logic [RAND_BITS+29:0] wp, wa;
  logic [29:0] up_nxt, ua_nxt;
  logic [31:0] span_w;
  logic [61:0] pc_nxt;
  logic [62:0] phi_full;
  logic signed [33:0] csum;
  logic [31:0] cost_nxt;
  logic signed [63:0] sq_w;
  logic [63:0] rad_w;
  logic [30:0] sint;
  ang_t cp, sp;
  logic signed [65:0] lp0, lp1;

  always_comb begin
    wp = {rand_polar, 30'd0};
    wa = {rand_azimuth, 30'd0};
    up_nxt = wp[RAND_BITS+29:RAND_BITS];
    ua_nxt = wa[RAND_BITS+29:RAND_BITS];
    span_w = 32'(ONE_Q30) - frame.minc;
    pc_nxt = 62'(span_w) * 62'(up_r);
    phi_full = 63'(ua_r) * 63'(TWO_PI_U);
    csum = $signed({{2{frame.minc[31]}}, frame.minc}) + $signed({2'b00, pc_r[61:30]});
    if (csum > 34'sd1073741824) begin
      cost_nxt = 32'(ONE_Q30);
    end else if (csum < -34'sd1073741824) begin
      cost_nxt = -32'(ONE_Q30);
    end else begin
      cost_nxt = csum[31:0];
    end
    sq_w = $signed(cost2_r) * $signed(cost2_r);
    rad_w = (64'd1 << 60) - sq_w;
    sint = qs_r[32].res[30:0];
    cp = rs_r[32].neg ? -rs_r[32].x : rs_r[32].x;
    sp = rs_r[32].neg ? -rs_r[32].y : rs_r[32].y;
    lp0 = $signed({1'b0, sint}) * cp;
    lp1 = $signed({1'b0, sint}) * sp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTAGE-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      up_r <= up_nxt;
      ua_r <= ua_nxt;
      pc_r <= pc_nxt;
      phi_r <= phi_full[62:30];
      cost2_r <= cost_nxt;
      rot2_r <= cordic_init($signed({1'b0, phi_r}));
      rs_r[0] <= rot2_r;
      cs_r[0] <= cost2_r;
      qs_r[0] <= '{rem: rad_w, res: 64'd0};
      loc0_r <= 34'(lp0 >>> 30);
      loc1_r <= 34'(lp1 >>> 30);
      loc2_r <= $signed(cs_r[32]);
    end
  end

  for (genvar j = 0; j < 32; j++) begin : g_iter
    always_ff @(posedge clk) begin
      if (adv) begin
        qs_r[j+1] <= root_step(qs_r[j], 64'd1 << (62 - 2 * j));
        cs_r[j+1] <= cs_r[j];
        if (j < 30) begin
          rs_r[j+1] <= cordic_step(rs_r[j], 5'(j));
        end else begin
          rs_r[j+1] <= rs_r[j];
        end
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_axis
    logic signed [65:0] m0, m1, m2;
    logic signed [63:0] acc, rnd;
    logic [17:0] sat;
    always_comb begin
      m0 = $signed(frame.rgt[k]) * loc0_r;
      m1 = $signed(frame.upv[k]) * loc1_r;
      m2 = $signed(frame.fwd[k]) * loc2_r;
      acc = pr_r[k][0] + pr_r[k][1] + pr_r[k][2];
      rnd = (acc + (64'sd1 <<< (59 - FRAC_BITS))) >>> (60 - FRAC_BITS);
      if (rnd > 64'sd131071) begin
        sat = 18'h1FFFF;
      end else if (rnd < -64'sd131072) begin
        sat = 18'h20000;
      end else begin
        sat = rnd[17:0];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        pr_r[k][0] <= m0[63:0];
        pr_r[k][1] <= m1[63:0];
        pr_r[k][2] <= m2[63:0];
        hd_r[k] <= sat;
      end
    end
  end

  assign out_valid = vld_r[NSTAGE-1];
  assign heading_x = $signed(hd_r[0]);
  assign heading_y = $signed(hd_r[1]);
  assign heading_z = $signed(hd_r[2]);

endmodule

@@ test/cone_direction_sampler_unit_test.sv @@
// Testbench for cone_direction_sampler_unit: table-driven directed items, then random
// items under random register settings, checked against a Q30 direction predictor.
// Depends on cds_pkg and the cone_direction_sampler_unit RTL.
`timescale 1ns / 1ps

module cone_direction_sampler_unit_test;
  import cds_pkg::*;

  localparam longint ONE = 64'sd1073741824;
  localparam longint PI = 64'sd3373259426;
  localparam longint HALF_PI = 64'sd1686629713;
  localparam longint THREE_HALF_PI = 64'sd5059889139;
  localparam longint TWO_PI = 64'sd6746518852;
  localparam longint CORDIC_K = 64'sd652032874;
  localparam longint NEAR_VERTICAL = 64'sd1063004406;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 142;

  typedef struct {
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic signed [17:0] z;
  } heading_t;

  typedef struct {
    logic [23:0] polar;
    logic [23:0] azimuth;
  } stim_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [23:0] in_rand_polar;
  logic [23:0] in_rand_azimuth;
  logic out_valid;
  logic out_stall;
  logic signed [17:0] out_heading_x;
  logic signed [17:0] out_heading_y;
  logic signed [17:0] out_heading_z;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [23:0] cfg_wdata;

  logic [17:0] half_angle_reg;
  logic signed [23:0] axis_reg [3];
  heading_t heading_q [$];
  int errors;
  int cycles;
  int stall_left;
  bit idle_on;
  stim_t directed [20];

  cone_direction_sampler_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_rand_polar(in_rand_polar), .in_rand_azimuth(in_rand_azimuth),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_heading_x(out_heading_x), .out_heading_y(out_heading_y),
    .out_heading_z(out_heading_z),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  task automatic rotate_sincos(input longint a, output longint c, output longint s);
    bit neg;
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    neg = 1'b0;
    x = CORDIC_K;
    y = 0;
    z = a;
    if (z > HALF_PI && z <= THREE_HALF_PI) begin
      z = z - PI;
      neg = 1'b1;
    end else if (z > THREE_HALF_PI) begin
      z = z - TWO_PI;
    end
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - longint'(atan_q30(5'(i)));
      end else begin
        x = x + dx; y = y - dy; z = z + longint'(atan_q30(5'(i)));
      end
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
  endtask

  task automatic unit_vector(input longint v [3], output longint o [3], output bit nonzero);
    logic [63:0] len2;
    logic [63:0] len;
    logic [63:0] m;
    longint q;
    int s;
    len2 = '0;
    for (int k = 0; k < 3; k++) begin
      m = v[k] < 0 ? -v[k] : v[k];
      len2 = len2 + m * m;
    end
    nonzero = len2 != 0;
    o = '{0, 0, 0};
    if (nonzero) begin
      s = 0;
      while (s < 30 && (len2 >> (60 - 2 * s)) == 0) s++;
      len = isqrt(len2 << (2 * s));
      for (int k = 0; k < 3; k++) begin
        m = v[k] < 0 ? -v[k] : v[k];
        q = longint'((m << (30 + s)) / len);
        q = clampl(q, 0, ONE);
        o[k] = v[k] < 0 ? -q : q;
      end
    end
  endtask

  task automatic predict_heading(input logic [23:0] polar, input logic [23:0] azimuth,
                                 output heading_t hd);
    longint h, cs, sn, minc, cost, sint, phi, cp, sp, acc, r;
    longint loc [3];
    longint axis [3];
    longint fwd [3];
    longint hc [3];
    longint rgt [3];
    longint upv [3];
    longint outv [3];
    bit nz;
    h = longint'(half_angle_reg) << 14;
    if (h > PI) h = PI;
    rotate_sincos(h, cs, sn);
    minc = clampl(cs, -ONE, ONE);
    cost = clampl(minc + (((ONE - minc) * (longint'(polar) << 6)) >>> 30), -ONE, ONE);
    sint = longint'(isqrt((64'd1 << 60) - 64'(cost * cost)));
    phi = ((longint'(azimuth) << 6) * TWO_PI) >>> 30;
    rotate_sincos(phi, cp, sp);
    loc[0] = (sint * cp) >>> 30;
    loc[1] = (sint * sp) >>> 30;
    loc[2] = cost;
    for (int k = 0; k < 3; k++) axis[k] = longint'(axis_reg[k]);
    unit_vector(axis, fwd, nz);
    if (!nz) fwd = '{0, ONE, 0};
    if ((fwd[1] < 0 ? -fwd[1] : fwd[1]) < NEAR_VERTICAL) hc = '{fwd[2], 0, -fwd[0]};
    else hc = '{0, -fwd[2], fwd[1]};
    unit_vector(hc, rgt, nz);
    if (!nz) rgt = '{ONE, 0, 0};
    upv[0] = (fwd[1] * rgt[2] - fwd[2] * rgt[1]) >>> 30;
    upv[1] = (fwd[2] * rgt[0] - fwd[0] * rgt[2]) >>> 30;
    upv[2] = (fwd[0] * rgt[1] - fwd[1] * rgt[0]) >>> 30;
    for (int k = 0; k < 3; k++) begin
      acc = rgt[k] * loc[0] + upv[k] * loc[1] + fwd[k] * loc[2];
      r = (acc + (64'sd1 <<< 43)) >>> 44;
      outv[k] = clampl(r, -131072, 131071);
    end
    hd.x = 18'(outv[0]);
    hd.y = 18'(outv[1]);
    hd.z = 18'(outv[2]);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_HALF_ANGLE: half_angle_reg = data[17:0];
      REG_AXIS_X: axis_reg[0] = data;
      REG_AXIS_Y: axis_reg[1] = data;
      REG_AXIS_Z: axis_reg[2] = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_cone(input logic [17:0] half, input logic [23:0] ax,
                          input logic [23:0] ay, input logic [23:0] az);
    write_reg(REG_HALF_ANGLE, {6'd0, half});
    write_reg(REG_AXIS_X, ax);
    write_reg(REG_AXIS_Y, ay);
    write_reg(REG_AXIS_Z, az);
  endtask

  task automatic send_item(input logic [23:0] polar, input logic [23:0] azimuth);
    int gap;
    heading_t hd;
    gap = idle_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rand_polar <= polar;
    in_rand_azimuth <= azimuth;
    predict_heading(polar, azimuth, hd);
    heading_q.push_back(hd);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (heading_q.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  function automatic logic [23:0] rand_fraction();
    case ($urandom_range(0, 9))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      2: return 24'(1 << $urandom_range(0, 23));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] rand_axis();
    case ($urandom_range(0, 7))
      0: return 24'h800000;
      1: return 24'h7FFFFF;
      2: return 24'h000000;
      3: return 24'($signed(24'($urandom_range(0, 15))) - 8);
      default: return 24'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    heading_t exp_hd;
    int stall_draw;
    if (!rst_n) begin
      stall_left <= 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (heading_q.size() == 0) begin
          $display("%0t: unexpected heading (%0d %0d %0d)", $time,
                   out_heading_x, out_heading_y, out_heading_z);
          errors++;
        end else begin
          exp_hd = heading_q.pop_front();
          if (out_heading_x !== exp_hd.x) begin
            $display("%0t: heading_x expected %0d actual %0d", $time, exp_hd.x, out_heading_x);
            errors++;
          end
          if (out_heading_y !== exp_hd.y) begin
            $display("%0t: heading_y expected %0d actual %0d", $time, exp_hd.y, out_heading_y);
            errors++;
          end
          if (out_heading_z !== exp_hd.z) begin
            $display("%0t: heading_z expected %0d actual %0d", $time, exp_hd.z, out_heading_z);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= (stall_left - 1) != 0;
      end else if (out_valid && !out_stall && idle_on) begin
        stall_draw = $urandom_range(0, 15);
        stall_left <= stall_draw;
        out_stall <= stall_draw != 0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    errors = 0;
    cycles = 0;
    idle_on = 1'b1;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_rand_polar = '0;
    in_rand_azimuth = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    half_angle_reg = '0;
    axis_reg[0] = 24'sd0;
    axis_reg[1] = 24'sd65536;
    axis_reg[2] = 24'sd0;
    directed = '{
      '{24'h000000, 24'h000000}, '{24'hFFFFFF, 24'hFFFFFF}, '{24'h000000, 24'hFFFFFF},
      '{24'hFFFFFF, 24'h000000}, '{24'h800000, 24'h400000}, '{24'h7FFFFF, 24'hC00000},
      '{24'h400000, 24'h800000}, '{24'h000001, 24'h200000}, '{24'hAAAAAA, 24'h555555},
      '{24'h555555, 24'hAAAAAA}, '{24'h123456, 24'hFEDCBA}, '{24'h0F0F0F, 24'hF0F0F0},
      '{24'hFFFFFE, 24'h600000}, '{24'h010000, 24'hA00000}, '{24'hE00000, 24'h000001},
      '{24'h200000, 24'hBFFFFF}, '{24'h300000, 24'h3FFFFF}, '{24'h900000, 24'hE00000},
      '{24'hC00000, 24'h7FFFFF}, '{24'h000100, 24'h40000F}
    };
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < 6; i++) send_item(directed[i].polar, directed[i].azimuth);
    drain();
    set_cone(18'd205887, 24'h000000, 24'h000000, 24'h000000);
    for (int i = 0; i < 6; i++) send_item(directed[i].polar, directed[i].azimuth);
    drain();
    set_cone(18'h3FFFF, 24'h7FFFFF, 24'h000000, 24'h800000);
    for (int i = 6; i < 13; i++) send_item(directed[i].polar, directed[i].azimuth);
    drain();
    set_cone(18'd25736, 24'h000100, 24'h800000, 24'h000000);
    write_reg(3'd4, 24'hFFFFFF);
    write_reg(3'd7, 24'h123456);
    for (int i = 13; i < 20; i++) send_item(directed[i].polar, directed[i].azimuth);
    drain();
    set_cone(18'd1, 24'h000001, 24'h00FD70, 24'hFFFFFF);
    for (int i = 0; i < 4; i++) send_item(directed[i].polar, directed[i].azimuth);
    drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      set_cone(ph == 0 ? 18'h3FFFF : 18'($urandom_range(0, 262143)),
               rand_axis(), rand_axis(), rand_axis());
      if ($urandom_range(0, 1)) write_reg(3'($urandom_range(4, 7)), 24'($urandom));
      idle_on = ph != 2;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_item(rand_fraction(), rand_fraction());
      drain();
    end

    if (errors == 0 && heading_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/cds_pkg.sv
design/cds_setup.sv
design/cds_item_pipe.sv
design/cone_direction_sampler_unit.sv
test/cone_direction_sampler_unit_test.sv
